// File: rtl/core/mat4_vec4_transform_core_macros.svh
// ---------------------------------------------------------------------------
// mat4 vec4 transform core assertion macros
// shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef MAT4_VEC4_TRANSFORM_CORE_MACROS_SVH
`define MAT4_VEC4_TRANSFORM_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define MVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mvt assertion failed");

// consequent must hold in the cycle after the antecedent
`define MVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mvt assertion failed");

`else

`define MVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/mvt_pkg.sv
// ---------------------------------------------------------------------------
// mvt_pkg
// shared types, register indexes and constants of the 4x4 transform core
// ---------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

	// default arithmetic format, signed q16.16
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// fixed widths of the transaction fields and the register file
	localparam int FIELD_W    = 32;
	localparam int NUM_REGS   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int HALF_W     = CFG_DATA_W / 2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

	typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] cfg_bank_t;

	// identity matrix after reset
	localparam cfg_bank_t CFG_RESET = '{
		REG_ROW0_COLS01: 64'h0000_0000_0001_0000,
		REG_ROW1_COLS01: 64'h0001_0000_0000_0000,
		REG_ROW2_COLS23: 64'h0000_0000_0001_0000,
		REG_ROW3_COLS23: 64'h0001_0000_0000_0000,
		default:         64'h0
	};

	// product orientation
	typedef enum logic {
		MODE_MAT_VEC = 1'b0,
		MODE_VEC_MAT = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic signed [31:0]  in_x;
		logic signed [31:0]  in_y;
		logic signed [31:0]  in_z;
		logic signed [31:0]  in_w;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0]  out_x;
		logic signed [31:0]  out_y;
		logic signed [31:0]  out_z;
		logic signed [31:0]  out_w;
		logic                saturated;
	} out_item_t;

	// handshake between front queue and back pipeline
	typedef struct packed {
		logic valid;
	} queue_status_t;

	typedef struct packed {
		logic pop;
	} queue_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/mat4_vec4_transform_core.sv
// an accepted transaction is queued, then passes through the pipeline stages to the output
// throughput: one vector per cycle, all pipeline stages advance together unless a result is held
// a four-entry queue at the input keeps taking transactions while a result is held, until it is full
// reset: matrix returns to identity, queue and pipeline empty, no result pending
// ---------------------------------------------------------------------------
// mat4_vec4_transform_core
// 4x4 matrix by 4-vector transform in signed fixed point, either orientation
// ---------------------------------------------------------------------------
`default_nettype none
`include "mat4_vec4_transform_core_macros.svh"

module mat4_vec4_transform_core #(
	parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              src_valid,
	output logic                             src_stall,
	input  mvt_pkg::in_item_t                src_item,
	output logic                             dst_valid,
	input  wire                              dst_stall,
	output mvt_pkg::out_item_t               dst_item,
	input  wire                              cfg_we,
	input  wire [mvt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [mvt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic signed [31:0] OUT_MAX = 32'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [31:0] OUT_MIN = 32'(-(64'sd1 <<< (DATA_WIDTH - 1)));

	mvt_pkg::cfg_bank_t     cfg_q;
	mvt_pkg::queue_status_t q_status;
	mvt_pkg::queue_ctrl_t   q_ctrl;
	mvt_pkg::in_item_t      q_item;
	logic                   dst_held;
	logic                   out_at_limit;

	// matrix coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mvt_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// input side and queue
	mvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.q_status  (q_status),
		.q_ctrl    (q_ctrl),
		.q_item    (q_item)
	);

	// arithmetic pipeline
	mvt_back #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.q_ctrl    (q_ctrl),
		.q_item    (q_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

	// result held by the receiver, and a component sitting at a range limit
	assign dst_held     = dst_valid && dst_stall;
	assign out_at_limit = (dst_item.out_x == OUT_MAX) || (dst_item.out_x == OUT_MIN) ||
	                      (dst_item.out_y == OUT_MAX) || (dst_item.out_y == OUT_MIN) ||
	                      (dst_item.out_z == OUT_MAX) || (dst_item.out_z == OUT_MIN) ||
	                      (dst_item.out_w == OUT_MAX) || (dst_item.out_w == OUT_MIN);

	// an accepted transaction leaves the queue nonempty
	`MVT_ASSERT_NEXT(a_push_visible, clk, arst_n, src_valid && !src_stall, q_status.valid)

	// the back drains the queue whenever its output is not held
	`MVT_ASSERT_NOW(a_pop_when_free, clk, arst_n, q_status.valid && !dst_held, q_ctrl.pop)

	// a clipped result has at least one component at a range limit
	`MVT_ASSERT_NOW(a_sat_at_limit, clk, arst_n, dst_valid && dst_item.saturated, out_at_limit)

endmodule

`default_nettype wire

// File: rtl/core/mvt_front.sv
// ---------------------------------------------------------------------------
// mvt_front
// accepts input transactions and holds them in a short queue for the back
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    src_valid,
	output logic                   src_stall,
	input  mvt_pkg::in_item_t      src_item,
	output mvt_pkg::queue_status_t q_status,
	input  mvt_pkg::queue_ctrl_t   q_ctrl,
	output mvt_pkg::in_item_t      q_item
);

	localparam int DEPTH = mvt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = mvt_pkg::QUEUE_PTR_W;
	localparam int CNT_W = mvt_pkg::QUEUE_CNT_W;

	mvt_pkg::in_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	// full queue pushes back on the source
	assign src_stall = (count_q == CNT_W'(DEPTH));
	assign push      = src_valid && !src_stall;
	assign pop       = q_ctrl.pop && (count_q != '0);

	assign q_status.valid = (count_q != '0);
	assign q_item         = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= src_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mvt_back.sv
// ---------------------------------------------------------------------------
// mvt_back
// four-stage multiply, add, round and saturate pipeline
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_back #(
	parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  mvt_pkg::cfg_bank_t     cfg,
	input  mvt_pkg::queue_status_t q_status,
	output mvt_pkg::queue_ctrl_t   q_ctrl,
	input  mvt_pkg::in_item_t      q_item,
	output logic                   dst_valid,
	input  wire                    dst_stall,
	output mvt_pkg::out_item_t     dst_item
);

	localparam int DW     = DATA_WIDTH;
	localparam int PROD_W = 2 * DW;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int HI_W   = SUM_W - DW + 1;
	localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

	logic                    adv;
	logic                    sel_vm;
	logic signed [DW-1:0]    vec [4];
	logic signed [DW-1:0]    coef [4][4];
	logic signed [PROD_W-1:0] prod_s1 [4][4];
	logic signed [PAIR_W-1:0] pair_s2 [4][2];
	logic signed [SUM_W-1:0]  sum_s3 [4];
	logic signed [DW-1:0]    clip [4];
	logic [3:0]              clip_hit;
	mvt_pkg::out_item_t      out_s4;
	logic                    v_s1;
	logic                    v_s2;
	logic                    v_s3;
	logic                    v_s4;

	// whole pipeline moves unless the finished result is held
	assign adv        = !(v_s4 && dst_stall);
	assign q_ctrl.pop = adv && q_status.valid;
	assign sel_vm     = (q_item.mode == mvt_pkg::MODE_VEC_MAT);

	// components narrowed to the data width
	assign vec[0] = q_item.in_x[DW-1:0];
	assign vec[1] = q_item.in_y[DW-1:0];
	assign vec[2] = q_item.in_z[DW-1:0];
	assign vec[3] = q_item.in_w[DW-1:0];

	// coefficient for output i and term j: row i col j, or row j col i
	for (genvar gi = 0; gi < 4; gi++) begin : g_out
		for (genvar gj = 0; gj < 4; gj++) begin : g_term
			localparam int RW = gi * 2 + gj / 2;
			localparam int RH = gj % 2;
			localparam int CW = gj * 2 + gi / 2;
			localparam int CH = gi % 2;
			assign coef[gi][gj] = sel_vm ? cfg[CW][CH*mvt_pkg::HALF_W +: DW]
			                             : cfg[RW][RH*mvt_pkg::HALF_W +: DW];
		end
	end

	// saturate the rounded sums to the data width
	always_comb begin
		logic signed [SUM_W-1:0] sh;
		logic [HI_W-1:0]         hi;
		for (int o = 0; o < 4; o++) begin
			sh = sum_s3[o] >>> FRAC_BITS;
			hi = sh[SUM_W-1:DW-1];
			clip_hit[o] = !((&hi) || (~|hi));
			if (clip_hit[o]) begin
				clip[o] = hi[HI_W-1] ? MIN_V : MAX_V;
			end else begin
				clip[o] = sh[DW-1:0];
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_status.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int o = 0; o < 4; o++) begin
				for (int t = 0; t < 4; t++) begin
					prod_s1[o][t] <= PROD_W'(coef[o][t]) * PROD_W'(vec[t]);
				end
				pair_s2[o][0] <= PAIR_W'(prod_s1[o][0]) + PAIR_W'(prod_s1[o][1]);
				pair_s2[o][1] <= PAIR_W'(prod_s1[o][2]) + PAIR_W'(prod_s1[o][3]);
				sum_s3[o]     <= SUM_W'(pair_s2[o][0]) + SUM_W'(pair_s2[o][1]) + RND;
			end
			out_s4.out_x     <= 32'(clip[0]);
			out_s4.out_y     <= 32'(clip[1]);
			out_s4.out_z     <= 32'(clip[2]);
			out_s4.out_w     <= 32'(clip[3]);
			out_s4.saturated <= |clip_hit;
		end
	end

	assign dst_valid = v_s4;
	assign dst_item  = out_s4;

endmodule

`default_nettype wire

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// mat4_vec4_transform_core testbench
// drives vectors through the 4x4 transform under several matrix settings and
// idle patterns, predicts every result in fixed point and checks it in order
// ---------------------------------------------------------------------------

module tb;

	import mvt_pkg::*;

	// run limits
	localparam int CLK_HALF       = 10;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int SEG_COUNT      = 8;
	localparam int SEG_ITEMS      = 220;

	// q16.16 reference values
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_HALF = 32'h0000_8000;
	localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;

	// saturation bounds of a 32-bit signed result
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
		REG_ROW0_COLS01, REG_ROW0_COLS23, REG_ROW1_COLS01, REG_ROW1_COLS23,
		REG_ROW2_COLS01, REG_ROW2_COLS23, REG_ROW3_COLS01, REG_ROW3_COLS23
	};

	typedef enum {MAT_FULL, MAT_SMALL, MAT_MAX, MAT_MIN, MAT_MIXED} mat_kind_t;

	localparam mat_kind_t SEG_KIND [SEG_COUNT] = '{
		MAT_SMALL, MAT_FULL, MAT_MIXED, MAT_SMALL, MAT_MAX, MAT_MIXED, MAT_MIN, MAT_SMALL
	};

	// idle patterns: none, sender only, receiver only, both
	localparam int SENDER_IDLE [4] = '{0, 49, 0, 38};
	localparam int RECV_STALL  [4] = '{0, 0, 49, 38};

	// ------------------------------------------------------------------
	// transform predictor and in-order result checker
	// ------------------------------------------------------------------
	class vec_transform_checker;
		cfg_bank_t coef_bank;
		out_item_t expected_outputs [$];
		int        errors;
		int        checked;
		int        clipped_seen;
		int        mode_count [2];

		function new();
			coef_bank = CFG_RESET;
		endfunction

		function void load_bank(cfg_bank_t b);
			coef_bank = b;
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction

		// coefficient of row r, column c
		function logic signed [31:0] coef_at(int r, int c);
			logic [63:0] word;
			word = coef_bank[r * 2 + c / 2];
			return (c % 2) ? $signed(word[63:32]) : $signed(word[31:0]);
		endfunction

		// exact sum of four products, round half up, saturate
		function out_item_t transform_vector(in_item_t it);
			logic signed [31:0] comp [4];
			logic signed [31:0] res [4];
			logic signed [31:0] m;
			logic signed [67:0] acc;
			longint             prod;
			longint             rounded;
			logic               clipped;
			out_item_t          o;
			comp[0] = it.in_x;
			comp[1] = it.in_y;
			comp[2] = it.in_z;
			comp[3] = it.in_w;
			clipped = 1'b0;
			for (int i = 0; i < 4; i++) begin
				acc = '0;
				for (int j = 0; j < 4; j++) begin
					m = (it.mode == MODE_VEC_MAT) ? coef_at(j, i) : coef_at(i, j);
					prod = longint'(m) * longint'(comp[j]);
					acc = acc + prod;
				end
				acc = acc + 68'sd32768;
				rounded = longint'(acc >>> 16);
				if (rounded > SAT_HI) begin
					rounded = SAT_HI;
					clipped = 1'b1;
				end else if (rounded < SAT_LO) begin
					rounded = SAT_LO;
					clipped = 1'b1;
				end
				res[i] = rounded[31:0];
			end
			o.out_x     = res[0];
			o.out_y     = res[1];
			o.out_z     = res[2];
			o.out_w     = res[3];
			o.saturated = clipped;
			return o;
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("MISMATCH: %s", what);
		endtask

		function void note_vector(in_item_t it);
			mode_count[it.mode]++;
			expected_outputs.push_back(transform_vector(it));
		endfunction

		task check_output(out_item_t got);
			out_item_t want;
			if (expected_outputs.size() == 0) begin
				report_mismatch($sformatf("result %h with no transaction outstanding", got));
				return;
			end
			want = expected_outputs.pop_front();
			checked++;
			if (want.saturated)
				clipped_seen++;
			if (got.out_x !== want.out_x)
				report_mismatch($sformatf("result %0d out_x %h, want %h",
					checked, got.out_x, want.out_x));
			if (got.out_y !== want.out_y)
				report_mismatch($sformatf("result %0d out_y %h, want %h",
					checked, got.out_y, want.out_y));
			if (got.out_z !== want.out_z)
				report_mismatch($sformatf("result %0d out_z %h, want %h",
					checked, got.out_z, want.out_z));
			if (got.out_w !== want.out_w)
				report_mismatch($sformatf("result %0d out_w %h, want %h",
					checked, got.out_w, want.out_w));
			if (got.saturated !== want.saturated)
				report_mismatch($sformatf("result %0d saturated %b, want %b",
					checked, got.saturated, want.saturated));
		endtask
	endclass

	// ------------------------------------------------------------------
	// signals and block instance
	// ------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_stall;
	in_item_t              src_item;
	logic                  dst_valid;
	logic                  dst_stall;
	out_item_t             dst_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vec_transform_checker sb;
	int                   idle_pct;
	int                   stall_pct;
	int                   settings_used;

	mat4_vec4_transform_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// hard stop if the block hangs
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("timeout after %0d cycles", TIMEOUT_CYCLES);
		$display("mat4_vec4_transform_core test failed");
		$finish;
	end

	// random receiver stall
	always @(posedge clk) begin
		dst_stall <= ($urandom_range(99) < stall_pct);
	end

	// record each accepted input transaction
	always @(posedge clk) begin
		if (arst_n && src_valid && !src_stall)
			sb.note_vector(src_item);
	end

	// check each accepted result transaction
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall)
			sb.check_output(dst_item);
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic in_item_t mk(mode_t md, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [31:0] w);
		in_item_t it;
		it.mode = md;
		it.in_x = x;
		it.in_y = y;
		it.in_z = z;
		it.in_w = w;
		return it;
	endfunction

	function automatic cfg_bank_t uniform_bank(logic [31:0] c);
		cfg_bank_t b;
		for (int k = 0; k < NUM_REGS; k++)
			b[REG_ORDER[k]] = {c, c};
		return b;
	endfunction

	function automatic logic [31:0] rand_coef(mat_kind_t kind);
		case (kind)
			MAT_SMALL: return 32'($urandom_range(524288)) - 32'd262144;
			MAT_MAX:   return ($urandom_range(3) == 0) ? 32'($urandom) : Q_MAX;
			MAT_MIN:   return ($urandom_range(3) == 0) ? 32'($urandom) : Q_MIN;
			MAT_MIXED: begin
				case ($urandom_range(5))
					0:       return Q_MAX;
					1:       return Q_MIN;
					2:       return '0;
					3:       return Q_ONE;
					4:       return 32'($urandom);
					default: return 32'($urandom_range(131072)) - 32'd65536;
				endcase
			end
			default:   return 32'($urandom);
		endcase
	endfunction

	function automatic cfg_bank_t random_bank(mat_kind_t kind);
		cfg_bank_t b;
		for (int k = 0; k < NUM_REGS; k++)
			b[REG_ORDER[k]] = {rand_coef(kind), rand_coef(kind)};
		return b;
	endfunction

	// full range, small magnitude or an edge value
	function automatic logic [31:0] rand_component();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4)
			return 32'($urandom);
		if (pick < 8)
			return 32'($urandom_range(2097152)) - 32'd1048576;
		case ($urandom_range(4))
			0:       return Q_MAX;
			1:       return Q_MIN;
			2:       return Q_NEG1;
			3:       return 32'd1;
			default: return '0;
		endcase
	endfunction

	function automatic in_item_t random_vector();
		return mk(mode_t'($urandom_range(1)), rand_component(), rand_component(),
			rand_component(), rand_component());
	endfunction

	// present one transaction, with random idle cycles ahead of it
	task automatic send_vector(in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
	endtask

	// hold off until every result is back and the pipeline is empty
	task automatic drain();
		src_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// write all eight registers back to back, block idle
	task automatic write_bank(cfg_bank_t b);
		for (int k = 0; k < NUM_REGS; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORDER[k];
			cfg_data  <= b[REG_ORDER[k]];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sb.load_bank(b);
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_bank_t ramp;
		sb            = new();
		idle_pct      = 0;
		stall_pct     = 0;
		settings_used = 1;
		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src_item  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset, edge components in both orientations
		send_vector(mk(MODE_MAT_VEC, '0, '0, '0, '0));
		send_vector(mk(MODE_MAT_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_vector(mk(MODE_VEC_MAT, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_vector(mk(MODE_MAT_VEC, Q_MAX, Q_MIN, Q_NEG1, 32'd1));
		send_vector(mk(MODE_VEC_MAT, Q_ONE, -Q_ONE, Q_HALF, 32'd3));

		// half coefficients: rounding ties go toward plus infinity
		drain();
		write_bank(uniform_bank(Q_HALF));
		send_vector(mk(MODE_MAT_VEC, 32'd1, '0, '0, '0));
		send_vector(mk(MODE_VEC_MAT, Q_NEG1, '0, '0, '0));
		send_vector(mk(MODE_MAT_VEC, -32'd3, '0, '0, '0));
		send_vector(mk(MODE_VEC_MAT, 32'd1, 32'd1, 32'd1, Q_NEG1));

		// largest coefficients: saturation both ways
		drain();
		write_bank(uniform_bank(Q_MAX));
		send_vector(mk(MODE_MAT_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_vector(mk(MODE_VEC_MAT, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_vector(mk(MODE_MAT_VEC, '0, '0, '0, '0));

		// most negative coefficients: product of two minimums overflows high
		drain();
		write_bank(uniform_bank(Q_MIN));
		send_vector(mk(MODE_VEC_MAT, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_vector(mk(MODE_MAT_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_vector(mk(MODE_VEC_MAT, 32'd1, Q_NEG1, 32'd1, Q_NEG1));

		// all-ones and all-zero registers
		drain();
		write_bank(uniform_bank(Q_NEG1));
		send_vector(mk(MODE_MAT_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_vector(mk(MODE_VEC_MAT, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		drain();
		write_bank(uniform_bank('0));
		send_vector(mk(MODE_MAT_VEC, Q_MAX, Q_MIN, 32'h1234_5678, Q_NEG1));

		// distinct coefficients so the two orientations differ
		drain();
		for (int k = 0; k < NUM_REGS; k++)
			ramp[REG_ORDER[k]] = {32'(2 * k + 2) * Q_ONE, -(32'(2 * k + 1) * Q_ONE)};
		write_bank(ramp);
		send_vector(mk(MODE_MAT_VEC, Q_ONE, '0, '0, '0));
		send_vector(mk(MODE_VEC_MAT, Q_ONE, '0, '0, '0));
		send_vector(mk(MODE_MAT_VEC, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE));

		// random segments, each with its own matrix and idle pattern
		for (int s = 0; s < SEG_COUNT; s++) begin
			drain();
			write_bank(random_bank(SEG_KIND[s]));
			idle_pct  = SENDER_IDLE[s % 4];
			stall_pct = RECV_STALL[s % 4];
			for (int k = 0; k < SEG_ITEMS; k++) begin
				// occasional full pause until the block has emptied
				if (k == SEG_ITEMS / 2 || $urandom_range(199) == 0)
					drain();
				send_vector(random_vector());
			end
		end

		// wait out the remaining results
		src_valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

		$display("sent %0d vectors (%0d matrix by vector, %0d vector by matrix) over %0d settings",
			sb.mode_count[0] + sb.mode_count[1], sb.mode_count[0], sb.mode_count[1],
			settings_used);
		$display("checked %0d results, %0d saturated, %0d mismatches",
			sb.checked, sb.clipped_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("mat4_vec4_transform_core test passed");
		end else begin
			$display("mat4_vec4_transform_core test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mvt_pkg.sv
rtl/core/mvt_front.sv
rtl/core/mvt_back.sv
rtl/core/mat4_vec4_transform_core.sv
verif/tb.sv
